[hw/rtl/line_splitter_with_overflow_drop_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the line splitter
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_SPLITTER_WITH_OVERFLOW_DROP_ASSERT_SVH
`define LINE_SPLITTER_WITH_OVERFLOW_DROP_ASSERT_SVH

// The expression must never be true at a clock edge outside reset.
`define LSPLIT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("line splitter: forbidden condition seen");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define LSPLIT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("line splitter: implication violated");

`endif

[hw/rtl/lsplit_pkg.sv]
// ----------------------------------------------------------------------------
// Line splitter package
// Shared constants and the controller state type.
// ----------------------------------------------------------------------------
package lsplit_pkg;

    localparam int LINE_CAPACITY_DEF = 64;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_EMIT
    } t_state;

endpackage

[hw/rtl/lsplit_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// its value while no read is requested.
// ----------------------------------------------------------------------------
module lsplit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/lsplit_ctrl.sv]
// ----------------------------------------------------------------------------
// Line splitter controller
// Stores incoming bytes in the line store, detects line ends, tracks
// overlong lines and streams a finished line out through an output register.
// ----------------------------------------------------------------------------
module lsplit_ctrl #(
    parameter int LINE_CAPACITY = lsplit_pkg::LINE_CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lsplit_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] byte_value
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lsplit_pkg::BYTE_W+lsplit_pkg::COUNT_W-1:0]
                                             m_axis_tdata,   // [7:0] line_byte,
                                                             // [39:8] truncated_lines
    output logic                             m_axis_tlast,
    output logic [0:0]                       m_axis_tuser,   // [0] empty_line
    // Line store port
    output logic                             o_wr_en,
    output logic [$clog2(LINE_CAPACITY)-1:0] o_wr_addr,
    output logic [lsplit_pkg::BYTE_W-1:0]    o_wr_data,
    output logic                             o_rd_en,
    output logic [$clog2(LINE_CAPACITY)-1:0] o_rd_addr,
    input  logic [lsplit_pkg::BYTE_W-1:0]    i_rd_data
);

    import lsplit_pkg::*;

    localparam int AW = $clog2(LINE_CAPACITY);
    localparam logic [AW-1:0] LEN_MAX = AW'(LINE_CAPACITY - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_len, n_len;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_dropping, n_dropping;
    logic                r_after_cr, n_after_cr;
    logic [COUNT_W-1:0]  r_dropped, n_dropped;

    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_empty;
    logic                r_out_last;
    logic [COUNT_W-1:0]  r_out_cnt;

    logic                w_is_term;
    logic                w_slot_free;
    logic                w_load;
    logic [BYTE_W-1:0]   w_load_byte;
    logic                w_load_empty;
    logic                w_load_last;

    assign w_is_term   = (s_axis_tdata == CHAR_CR) || (s_axis_tdata == CHAR_LF);
    assign w_slot_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_dropping  <= 1'b0;
            r_after_cr  <= 1'b0;
            r_dropped   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_dropping  <= n_dropping;
            r_after_cr  <= n_after_cr;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // The count is captured with each result, since a later line may bump
    // it while this result is still waiting to be taken.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte  <= w_load_byte;
            r_out_empty <= w_load_empty;
            r_out_last  <= w_load_last;
            r_out_cnt   <= r_dropped;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_idx         = r_idx;
        n_dropping    = r_dropping;
        n_after_cr    = r_after_cr;
        n_dropped     = r_dropped;
        s_axis_tready = 1'b0;
        o_wr_en       = 1'b0;
        o_wr_addr     = r_len;
        o_wr_data     = s_axis_tdata;
        o_rd_en       = 1'b0;
        o_rd_addr     = r_idx;
        w_load        = 1'b0;
        w_load_byte   = i_rd_data;
        w_load_empty  = 1'b0;
        w_load_last   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (r_after_cr && (s_axis_tdata == CHAR_LF)) begin
                        // The LF of a CRLF pair has already been accounted for.
                        n_after_cr = 1'b0;
                    end else if (w_is_term) begin
                        n_after_cr = (s_axis_tdata == CHAR_CR);
                        if (r_dropping) begin
                            n_len      = '0;
                            n_dropping = 1'b0;
                            if (r_dropped != '1) begin
                                n_dropped = r_dropped + 1'b1;
                            end
                        end else if (r_len == '0) begin
                            if (w_slot_free) begin
                                w_load       = 1'b1;
                                w_load_byte  = '0;
                                w_load_empty = 1'b1;
                                w_load_last  = 1'b1;
                            end else begin
                                n_state = ST_EMPTY;
                            end
                        end else begin
                            // Start the read of the first stored byte.
                            o_rd_en   = 1'b1;
                            o_rd_addr = '0;
                            n_idx     = '0;
                            n_state   = ST_EMIT;
                        end
                    end else begin
                        n_after_cr = 1'b0;
                        if (!r_dropping) begin
                            if (r_len < LEN_MAX) begin
                                o_wr_en = 1'b1;
                                n_len   = r_len + 1'b1;
                            end else begin
                                n_dropping = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_EMPTY: begin
                if (w_slot_free) begin
                    w_load       = 1'b1;
                    w_load_byte  = '0;
                    w_load_empty = 1'b1;
                    w_load_last  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // Read data for r_idx is at the RAM output; it holds while stalled.
                if (w_slot_free) begin
                    w_load      = 1'b1;
                    w_load_last = (r_idx == r_len - 1'b1);
                    if (w_load_last) begin
                        n_len   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_idx + 1'b1;
                        n_idx     = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_cnt, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_empty;

endmodule

[hw/rtl/line_splitter_with_overflow_drop.sv]
// ----------------------------------------------------------------------------
// Line splitter with overflow drop
// Splits a byte stream into lines at CR, LF or CRLF and streams each line out.
// ----------------------------------------------------------------------------
// Each ordinary byte is accepted and written into the line store, which
// holds up to LINE_CAPACITY-1 bytes. A terminator of a line keeps the input
// stalled while the line is read back through the single read port of the
// store; the first read is started in the cycle that takes the terminator,
// so one result follows per cycle while the output is not stalled.
// Back-pressure on the output adds its own stall cycles. An empty line gives
// one result with empty_line set in tuser. Bytes beyond the capacity are
// discarded, such a line gives no results, and the saturating truncated-line
// count in the upper tdata bits goes up by one. The line store needs no
// initialisation after reset.
module line_splitter_with_overflow_drop #(
    parameter int LINE_CAPACITY = lsplit_pkg::LINE_CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lsplit_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] byte_value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lsplit_pkg::BYTE_W+lsplit_pkg::COUNT_W-1:0]
                                          m_axis_tdata,   // [7:0] line_byte,
                                                          // [39:8] truncated_lines
    output logic                          m_axis_tlast,   // last_of_line
    output logic [0:0]                    m_axis_tuser    // [0] empty_line
);

    import lsplit_pkg::*;

    localparam int AW = $clog2(LINE_CAPACITY);

    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [BYTE_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [BYTE_W-1:0] w_rd_data;

    lsplit_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data)
    );

    lsplit_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

`include "line_splitter_with_overflow_drop_assert.svh"

    // Filling and reading back the store are never interleaved.
    `LSPLIT_ASSERT_NEVER(a_no_rw_overlap, i_clk, i_rst_n, w_wr_en && w_rd_en)

    // An empty line is always a run of exactly one result.
    `LSPLIT_ASSERT_IMPLY(a_empty_is_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[7:0] == '0))

    // A byte is only written while an input item is being accepted.
    `LSPLIT_ASSERT_IMPLY(a_wr_on_accept, i_clk, i_rst_n,
        w_wr_en, s_axis_tvalid && s_axis_tready)

    // The truncated-line count shown on the results never goes down.
    `LSPLIT_ASSERT_IMPLY(a_count_mono, i_clk, i_rst_n,
        $past(i_rst_n) && $past(m_axis_tvalid) && m_axis_tvalid,
        m_axis_tdata[39:8] >= $past(m_axis_tdata[39:8]))

endmodule
